/* hdl/rag_pkg.sv */
package rag_pkg;

	localparam int DATA_W  = 32;
	localparam int COORD_W = 8;

	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	// register index taken from paddr[2]
	localparam logic REG_INIT_VALUE = 1'b0;

	localparam logic signed [DATA_W-1:0] MIN_IDENTITY = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [DATA_W-1:0] min;
		logic signed [DATA_W-1:0] tag;
		logic                     pend;
	} node_word_t;

	localparam int NODE_W = $bits(node_word_t);

	typedef struct packed {
		logic clear;
		logic load;
		logic read;
		logic eval;
		logic push;
		logic clrp;
		logic desc;
		logic up;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic cfg_wr;
		logic clr_done;
		logic empty;
		logic disj;
		logic cov;
		logic pend;
		logic push_last;
		logic is_query;
		logic dep_zero;
		logic top_last;
		logic out_busy;
	} ctl_sts_t;

endpackage

/* hdl/rag_ram.sv */
module rag_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 87381
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/rag_ctrl.sv */
module rag_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rag_pkg::ctl_sts_t sts,
	output rag_pkg::ctl_cmd_t cmd
);
	import rag_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK, ST_READ, ST_EVAL,
		ST_PUSH, ST_CLRP, ST_DESC, ST_UP, ST_DONE
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE) || sts.cfg_wr;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_done && !sts.cfg_wr) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (sts.cfg_wr) begin
					state_d = ST_CLEAR;
				end else if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = sts.empty ? ST_DONE : ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				priority if (sts.disj || sts.cov) begin
					state_d = ST_UP;
				end else if (sts.pend) begin
					state_d = ST_PUSH;
				end else begin
					state_d = ST_DESC;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				if (sts.push_last) begin
					state_d = sts.is_query ? ST_CLRP : ST_DESC;
				end
			end
			ST_CLRP: begin
				cmd.clrp = 1'b1;
				state_d  = ST_DESC;
			end
			ST_DESC: begin
				cmd.desc = 1'b1;
				state_d  = ST_READ;
			end
			ST_UP: begin
				cmd.up = 1'b1;
				priority if (sts.dep_zero) begin
					state_d = ST_DONE;
				end else if (!sts.top_last) begin
					state_d = ST_DESC;
				end
			end
			ST_DONE: begin
				if (!(sts.is_query && sts.out_busy)) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/rag_dpath.sv */
module rag_dpath #(
	parameter int GRID_LOG2 = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rag_pkg::ctl_cmd_t                  cmd,
	output rag_pkg::ctl_sts_t                  sts,
	input  logic                               cfg_wr,
	input  logic signed [rag_pkg::DATA_W-1:0]  cfg_data,
	output logic signed [rag_pkg::DATA_W-1:0]  init_value,
	input  logic                               in_cmd,
	input  logic [rag_pkg::COORD_W-1:0]        in_row_lo,
	input  logic [rag_pkg::COORD_W-1:0]        in_col_lo,
	input  logic [rag_pkg::COORD_W-1:0]        in_row_hi,
	input  logic [rag_pkg::COORD_W-1:0]        in_col_hi,
	input  logic signed [rag_pkg::DATA_W-1:0]  in_value,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic signed [rag_pkg::DATA_W-1:0]  out_min
);
	import rag_pkg::*;

	localparam int NODE_COUNT = ((1 << (2 * GRID_LOG2 + 2)) - 1) / 3;
	localparam int NW  = $clog2(NODE_COUNT);
	localparam int CW  = (GRID_LOG2 > COORD_W ? GRID_LOG2 : COORD_W) + 2;
	localparam int DW  = $clog2(GRID_LOG2 + 1);
	localparam int SW  = (GRID_LOG2 > 1) ? $clog2(GRID_LOG2) : 1;
	localparam int STK = 1 << SW;
	localparam logic [CW-1:0] EDGE     = CW'((1 << GRID_LOG2) - 1);
	localparam logic [DW-1:0] LVL_ROOT = DW'(GRID_LOG2);
	localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);

	logic signed [DATA_W-1:0] init_q;
	logic [CW-1:0]            rlo_q, clo_q, rhi_q, chi_q;
	logic signed [DATA_W-1:0] val_q;
	logic                     query_q;

	logic [NW-1:0]            cur_n_q;
	logic [CW-1:0]            cur_r_q, cur_c_q;
	logic [DW-1:0]            dep_q;

	logic [NW-1:0]            stk_n_q   [STK];
	logic [CW-1:0]            stk_r_q   [STK];
	logic [CW-1:0]            stk_c_q   [STK];
	logic [1:0]               stk_k_q   [STK];
	logic signed [DATA_W-1:0] stk_m_q   [STK];
	logic signed [DATA_W-1:0] stk_tag_q [STK];

	logic signed [DATA_W-1:0] ret_q, best_q, out_q;
	logic                     have_q, out_valid_q;
	logic [1:0]               pk_q;
	logic [NW-1:0]            clr_cnt_q;

	logic [CW-1:0]            size, rend, cend, rhi_clip, chi_clip;
	logic [DW-1:0]            top_full;
	logic [SW-1:0]            top_idx, push_idx;
	logic [NW+1:0]            push_full, desc_full;
	logic signed [DATA_W-1:0] newm;
	logic                     disj, cov, clr_done, top_last, dep_zero;
	node_word_t               rd, wd;
	logic [NODE_W-1:0]        rdata;
	logic                     we;
	logic [NW-1:0]            waddr;

	assign size     = CW'(1) << (LVL_ROOT - dep_q);
	assign rend     = cur_r_q + size - CW'(1);
	assign cend     = cur_c_q + size - CW'(1);
	assign top_full = dep_q - DW'(1);
	assign top_idx  = top_full[SW-1:0];
	assign push_idx = dep_q[SW-1:0];
	assign dep_zero = (dep_q == '0);
	assign top_last = (stk_k_q[top_idx] == 2'd3);
	assign clr_done = (clr_cnt_q == LAST_NODE);
	assign rd       = node_word_t'(rdata);

	assign push_full = {stk_n_q[top_idx], pk_q} + (NW+2)'(1);
	assign desc_full = {stk_n_q[top_idx], stk_k_q[top_idx]} + (NW+2)'(1);

	assign newm = (ret_q < stk_m_q[top_idx]) ? ret_q : stk_m_q[top_idx];

	assign disj = (rhi_q < cur_r_q) || (rlo_q > rend) || (chi_q < cur_c_q) || (clo_q > cend);
	assign cov  = (rlo_q <= cur_r_q) && (rend <= rhi_q) && (clo_q <= cur_c_q) && (cend <= chi_q);

	assign rhi_clip = (CW'(in_row_hi) > EDGE) ? EDGE : CW'(in_row_hi);
	assign chi_clip = (CW'(in_col_hi) > EDGE) ? EDGE : CW'(in_col_hi);

	always_comb begin
		we    = 1'b0;
		waddr = clr_cnt_q;
		wd    = '{min: init_q, tag: init_q, pend: 1'b0};
		priority if (cmd.clear) begin
			we = 1'b1;
		end else if (cmd.eval && !disj && cov && !query_q) begin
			we    = 1'b1;
			waddr = cur_n_q;
			wd    = '{min: val_q, tag: val_q, pend: 1'b1};
		end else if (cmd.push) begin
			we    = 1'b1;
			waddr = push_full[NW-1:0];
			wd    = '{min: stk_tag_q[top_idx], tag: stk_tag_q[top_idx], pend: 1'b1};
		end else if (cmd.clrp) begin
			we    = 1'b1;
			waddr = stk_n_q[top_idx];
			wd    = '{min: stk_m_q[top_idx], tag: stk_tag_q[top_idx], pend: 1'b0};
		end else if (cmd.up && !dep_zero && top_last && !query_q) begin
			we    = 1'b1;
			waddr = stk_n_q[top_idx];
			wd    = '{min: newm, tag: stk_tag_q[top_idx], pend: 1'b0};
		end
	end

	rag_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wd),
		.raddr (cur_n_q),
		.rdata (rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '0;
			clr_cnt_q   <= '0;
			dep_q       <= '0;
			pk_q        <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
			query_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				init_q    <= cfg_data;
				clr_cnt_q <= '0;
			end else if (cmd.clear) begin
				clr_cnt_q <= clr_done ? '0 : clr_cnt_q + NW'(1);
			end
			if (cmd.load) begin
				query_q <= in_cmd;
				dep_q   <= '0;
				have_q  <= 1'b0;
			end
			if (cmd.eval && !disj && cov && query_q) begin
				have_q <= 1'b1;
			end
			if (cmd.eval && !disj && !cov) begin
				dep_q <= dep_q + DW'(1);
				pk_q  <= '0;
			end
			if (cmd.push) begin
				pk_q <= pk_q + 2'd1;
			end
			if (cmd.up && !dep_zero && top_last) begin
				dep_q <= dep_q - DW'(1);
			end
			if (cmd.finish && query_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rlo_q   <= CW'(in_row_lo);
			clo_q   <= CW'(in_col_lo);
			rhi_q   <= rhi_clip;
			chi_q   <= chi_clip;
			val_q   <= in_value;
			cur_n_q <= '0;
			cur_r_q <= '0;
			cur_c_q <= '0;
		end
		if (cmd.eval) begin
			if (disj) begin
				ret_q <= rd.min;
			end else if (cov) begin
				ret_q <= val_q;
				if (query_q && (!have_q || rd.min < best_q)) begin
					best_q <= rd.min;
				end
			end else begin
				stk_n_q[push_idx]   <= cur_n_q;
				stk_r_q[push_idx]   <= cur_r_q;
				stk_c_q[push_idx]   <= cur_c_q;
				stk_k_q[push_idx]   <= '0;
				stk_m_q[push_idx]   <= query_q ? rd.min : MIN_IDENTITY;
				stk_tag_q[push_idx] <= rd.tag;
			end
		end
		// child k: bit 0 steps down the rows, bit 1 across the columns
		if (cmd.desc) begin
			cur_n_q <= desc_full[NW-1:0];
			cur_r_q <= stk_r_q[top_idx] + (stk_k_q[top_idx][0] ? size : '0);
			cur_c_q <= stk_c_q[top_idx] + (stk_k_q[top_idx][1] ? size : '0);
		end
		if (cmd.up && !dep_zero) begin
			if (top_last) begin
				ret_q <= newm;
			end else begin
				stk_k_q[top_idx] <= stk_k_q[top_idx] + 2'd1;
				stk_m_q[top_idx] <= newm;
			end
		end
		if (cmd.finish && query_q) begin
			out_q <= have_q ? best_q : init_q;
		end
	end

	assign init_value = init_q;
	assign out_valid  = out_valid_q;
	assign out_min    = out_q;

	assign sts.cfg_wr    = cfg_wr;
	assign sts.clr_done  = clr_done;
	assign sts.empty     = (rlo_q > rhi_q) || (clo_q > chi_q);
	assign sts.disj      = disj;
	assign sts.cov       = cov;
	assign sts.pend      = rd.pend;
	assign sts.push_last = (pk_q == 2'd3);
	assign sts.is_query  = query_q;
	assign sts.dep_zero  = dep_zero;
	assign sts.top_last  = top_last;
	assign sts.out_busy  = out_valid_q && out_stall;

endmodule

/* hdl/rect_assign_range_min_grid_core.sv */
// Square grid of 2^GRID_LOG2 by 2^GRID_LOG2 signed 32-bit cells kept as a full
// quadtree in one node memory (min, pending tag, tag valid per node). cmd 0
// assigns value to an inclusive rectangle with no result, cmd 1 returns the
// rectangle minimum (init_value for an empty rectangle). One command at a time:
// each node visited is read, evaluated, descended into and returned from
// through the one node memory, with four writes when a pending tag is pushed
// down and one more to clear it on a query.
// After reset, and after a write of init_value while no command is in flight, a
// clearing pass sweeps all (4^(GRID_LOG2+1)-1)/3 nodes (87381 at the default)
// of the memory, and no command is taken until it ends.
module rect_assign_range_min_grid_core #(
	parameter int GRID_LOG2 = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic [rag_pkg::COORD_W-1:0]        row_lo,
	input  logic [rag_pkg::COORD_W-1:0]        col_lo,
	input  logic [rag_pkg::COORD_W-1:0]        row_hi,
	input  logic [rag_pkg::COORD_W-1:0]        col_hi,
	input  logic signed [rag_pkg::DATA_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [rag_pkg::DATA_W-1:0]  min_value
);
	import rag_pkg::*;

	ctl_cmd_t                 ctl_cmd;
	ctl_sts_t                 sts;
	logic                     cfg_wr;
	logic signed [DATA_W-1:0] init_value;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_INIT_VALUE);
	assign prdata = (paddr[2] == REG_INIT_VALUE) ? init_value : '0;

	rag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (ctl_cmd)
	);

	rag_dpath #(.GRID_LOG2(GRID_LOG2)) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl_cmd),
		.sts        (sts),
		.cfg_wr     (cfg_wr),
		.cfg_data   (pwdata),
		.init_value (init_value),
		.in_cmd     (cmd),
		.in_row_lo  (row_lo),
		.in_col_lo  (col_lo),
		.in_row_hi  (row_hi),
		.in_col_hi  (col_hi),
		.in_value   (value),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_min    (min_value)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transaction taken while a command is in flight");

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> sts.is_query)
		else $error("result raised for an assign command");

	a_clear_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> in_stall)
		else $error("commands taken before the clearing pass");

endmodule
